// ----- src/afnm_pkg.sv -----
// Package of types and constants shared by the aspect-fit scaler map block.
package afnm_pkg;

    localparam int DIM_W       = 12;
    localparam int STRIDE_W    = 16;
    localparam int FB_W        = 32;
    localparam int OFFSET_W    = 30;
    localparam int LINE_W      = 29;
    localparam int DVD_W       = 2 * DIM_W;
    localparam int FIT_DIV_STEPS = 2 * DIM_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_X         = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_Y         = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_BYTES      = 4'd7;

    localparam logic [DIM_W-1:0]    RST_SOURCE_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0]    RST_SOURCE_HEIGHT = 12'd240;
    localparam logic [DIM_W-1:0]    RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [DIM_W-1:0]    RST_SCREEN_HEIGHT = 12'd768;
    localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE   = 16'd4096;
    localparam logic [FB_W-1:0]     RST_FB_BYTES      = 32'd3145728;
    localparam logic [DIM_W-1:0]    RST_FIT_WIDTH     = 12'd1024;
    localparam logic [DIM_W-1:0]    RST_FIT_HEIGHT    = 12'd768;

    typedef struct packed {
        logic [DIM_W-1:0] dest_x;
        logic [DIM_W-1:0] dest_y;
    } item_t;

    typedef struct packed {
        logic                in_image;
        logic [DIM_W-1:0]    src_col;
        logic [DIM_W-1:0]    src_row;
        logic [OFFSET_W-1:0] fb_offset;
        logic                write_ok;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0]    src_width;
        logic [DIM_W-1:0]    source_height;
        logic [DIM_W-1:0]    screen_width;
        logic [DIM_W-1:0]    screen_height;
        logic [STRIDE_W-1:0] line_stride;
        logic [DIM_W-1:0]    pan_x;
        logic [DIM_W-1:0]    pan_y;
        logic [FB_W-1:0]     fb_bytes;
        logic [DIM_W-1:0]    fit_width;
        logic [DIM_W-1:0]    fit_height;
        logic [DIM_W-1:0]    margin_x;
        logic [DIM_W-1:0]    margin_y;
    } cfg_t;

    typedef struct packed {
        logic                in_image;
        logic                write_ok;
        logic [OFFSET_W-1:0] fb_offset;
        logic [DVD_W-1:0]    col_num;
        logic [DVD_W-1:0]    row_num;
    } job_t;

    typedef enum logic [2:0] {
        FIT_IDLE,
        FIT_START,
        FIT_DIV_H,
        FIT_DIV_W,
        FIT_FINISH
    } fit_state_t;

endpackage

// ----- src/afnm_fit.sv -----
// Configuration registers and the sequencer that fits and centres the scaled image.
module afnm_fit
    import afnm_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FB_W-1:0]      cfg_data,
    output cfg_t                 cfg,
    output logic                 busy
);

    fit_state_t       state_reg, state_next;
    cfg_t             cfg_reg, cfg_next;
    logic [DIM_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0] dsr_reg, dsr_next;
    logic [4:0]       cnt_reg, cnt_next;

    logic [DIM_W:0]   trial;
    logic             fits;
    logic [DIM_W-1:0] rem_step;
    logic [DVD_W-1:0] quo_step;
    logic [DIM_W-1:0] cap_val;

    // Dimension registers keep the low 12 bits of the data, limited to MAX_DIM - 1.
    assign cap_val = ({20'd0, cfg_data[DIM_W-1:0]} > 32'(MAX_DIM - 1)) ?
                     DIM_W'(MAX_DIM - 1) : cfg_data[DIM_W-1:0];

    // One quotient bit per cycle of the shared restoring divider.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_step = fits ? DIM_W'(trial - {1'b0, dsr_reg}) : trial[DIM_W-1:0];
    assign quo_step = {quo_reg[DVD_W-2:0], fits};

    always_comb
    begin
        state_next = state_reg;
        cfg_next   = cfg_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            FIT_IDLE:
            begin
            end
            FIT_START:
            begin
                if (cfg_reg.src_width == '0 || cfg_reg.source_height == '0)
                begin
                    cfg_next.fit_width  = '0;
                    cfg_next.fit_height = '0;
                    state_next = FIT_FINISH;
                end
                else
                begin
                    dvd_next   = cfg_reg.source_height * cfg_reg.screen_width;
                    dsr_next   = cfg_reg.src_width;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = FIT_DIV_H;
                end
            end
            FIT_DIV_H:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(FIT_DIV_STEPS - 1))
                begin
                    if (quo_step > {12'd0, cfg_reg.screen_height})
                    begin
                        dvd_next   = cfg_reg.src_width * cfg_reg.screen_height;
                        dsr_next   = cfg_reg.source_height;
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = FIT_DIV_W;
                    end
                    else
                    begin
                        cfg_next.fit_width  = cfg_reg.screen_width;
                        cfg_next.fit_height = quo_step[DIM_W-1:0];
                        state_next = FIT_FINISH;
                    end
                end
            end
            FIT_DIV_W:
            begin
                rem_next = rem_step;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                quo_next = quo_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(FIT_DIV_STEPS - 1))
                begin
                    cfg_next.fit_width  = quo_step[DIM_W-1:0];
                    cfg_next.fit_height = cfg_reg.screen_height;
                    state_next = FIT_FINISH;
                end
            end
            FIT_FINISH:
            begin
                cfg_next.margin_x = DIM_W'((cfg_reg.screen_width - cfg_reg.fit_width) >> 1);
                cfg_next.margin_y = DIM_W'((cfg_reg.screen_height - cfg_reg.fit_height) >> 1);
                state_next = FIT_IDLE;
            end
            default:
            begin
                state_next = FIT_IDLE;
            end
        endcase

        // A register write restarts the fit from the new values; an unknown index
        // leaves everything, including a fit in progress, untouched.
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  cfg_next.src_width     = cap_val;
                REG_SOURCE_HEIGHT: cfg_next.source_height = cap_val;
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cap_val;
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cap_val;
                REG_LINE_STRIDE:   cfg_next.line_stride   = cfg_data[STRIDE_W-1:0];
                REG_PAN_X:         cfg_next.pan_x         = cfg_data[DIM_W-1:0];
                REG_PAN_Y:         cfg_next.pan_y         = cfg_data[DIM_W-1:0];
                REG_FB_BYTES:      cfg_next.fb_bytes      = cfg_data;
                default:           ;
            endcase
            if (cfg_index <= REG_FB_BYTES)
            begin
                state_next = FIT_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= FIT_IDLE;
            cfg_reg.src_width     <= RST_SOURCE_WIDTH;
            cfg_reg.source_height <= RST_SOURCE_HEIGHT;
            cfg_reg.screen_width  <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= RST_SCREEN_HEIGHT;
            cfg_reg.line_stride   <= RST_LINE_STRIDE;
            cfg_reg.pan_x         <= '0;
            cfg_reg.pan_y         <= '0;
            cfg_reg.fb_bytes      <= RST_FB_BYTES;
            cfg_reg.fit_width     <= RST_FIT_WIDTH;
            cfg_reg.fit_height    <= RST_FIT_HEIGHT;
            cfg_reg.margin_x      <= '0;
            cfg_reg.margin_y      <= '0;
            cnt_reg               <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign cfg  = cfg_reg;
    assign busy = state_reg != FIT_IDLE;

endmodule

// ----- src/afnm_front.sv -----
// Front part: classifies each pixel, forms the offset, bounds check and dividends.
module afnm_front
    import afnm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item,
    input  cfg_t  cfg,
    output logic  push,
    output job_t  job
);

    logic               a_valid_reg;
    logic [DIM_W-1:0]   a_dx_reg;
    logic               a_vis_reg;
    logic               a_hit_reg;
    logic [LINE_W-1:0]  a_line_reg;
    logic [DVD_W-1:0]   a_col_reg;
    logic [DVD_W:0]     a_row_reg;
    logic               push_reg;
    job_t               job_reg;

    logic               vis, hx, hy;
    logic [DIM_W-1:0]   u, t;
    logic [DIM_W:0]     sum_x, sum_mx;
    logic [FB_W:0]      row_end;

    assign vis = item.dest_x < cfg.screen_width && item.dest_y < cfg.screen_height;
    assign hx  = item.dest_x >= cfg.margin_x &&
                 {1'b0, item.dest_x} < ({1'b0, cfg.margin_x} + {1'b0, cfg.fit_width});
    assign hy  = item.dest_y >= cfg.margin_y &&
                 {1'b0, item.dest_y} < ({1'b0, cfg.margin_y} + {1'b0, cfg.fit_height});
    assign u   = item.dest_x - cfg.margin_x;
    assign t   = item.dest_y - cfg.margin_y;

    always_ff @(posedge clk)
    begin
        a_dx_reg   <= item.dest_x;
        a_vis_reg  <= vis;
        a_hit_reg  <= vis && hx && hy;
        a_line_reg <= LINE_W'({1'b0, item.dest_y} + {1'b0, cfg.pan_y})
                    * LINE_W'(cfg.line_stride);
        a_col_reg  <= u * cfg.src_width;
        a_row_reg  <= ({1'b0, t} + 13'd1) * cfg.source_height;
    end

    assign sum_x   = {1'b0, a_dx_reg} + {1'b0, cfg.pan_x};
    assign sum_mx  = {1'b0, cfg.margin_x} + {1'b0, cfg.pan_x};
    // The whole image row has to end inside framebuffer memory.
    assign row_end = (FB_W+1)'(a_line_reg) + (FB_W+1)'({sum_mx, 2'b00})
                   + (FB_W+1)'({cfg.fit_width, 2'b00});

    always_ff @(posedge clk)
    begin
        job_reg.in_image  <= a_hit_reg;
        job_reg.write_ok  <= a_vis_reg && (!a_hit_reg || row_end <= {1'b0, cfg.fb_bytes});
        job_reg.fb_offset <= OFFSET_W'(a_line_reg) + OFFSET_W'({sum_x, 2'b00});
        job_reg.col_num   <= a_col_reg;
        job_reg.row_num   <= DVD_W'(a_row_reg - 25'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            push_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            push_reg    <= a_valid_reg;
        end
    end

    assign push = push_reg;
    assign job  = job_reg;

endmodule

// ----- src/afnm_fifo.sv -----
// Short queue of classified pixels between the front and back parts.
module afnm_fifo
    import afnm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  job_t                  push_job,
    input  logic                  pop,
    output logic                  not_empty,
    output job_t                  head,
    output logic [FIFO_CNT_W-1:0] level
);

    job_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_pop;

    assign do_pop = pop && count_reg != '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
        end
    end

    assign not_empty = count_reg != '0;
    assign head      = mem[rd_ptr_reg];
    assign level     = count_reg;

endmodule

// ----- src/afnm_div_pipe.sv -----
// Pipelined restoring divider giving one quotient bit per stage.
module afnm_div_pipe
    import afnm_pkg::*;
(
    input  logic             clk,
    input  logic [DVD_W-1:0] num,
    input  logic [DIM_W-1:0] den,
    output logic [DIM_W-1:0] quo
);

    logic [DIM_W-1:0] rem_reg [DIM_W];
    logic [DIM_W-1:0] low_reg [DIM_W];
    logic [DIM_W-1:0] q_reg   [DIM_W];

    // The numerator is below den times 4096, so the upper half starts below den.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM_W; i++)
        begin
            logic [DIM_W-1:0] r_in, l_in, q_in;
            logic [DIM_W:0]   trial;
            logic             ge;
            r_in  = (i == 0) ? num[DVD_W-1:DIM_W] : rem_reg[i-1];
            l_in  = (i == 0) ? num[DIM_W-1:0]     : low_reg[i-1];
            q_in  = (i == 0) ? '0                 : q_reg[i-1];
            trial = {r_in, l_in[DIM_W-1]};
            ge    = trial >= {1'b0, den};
            rem_reg[i] <= ge ? DIM_W'(trial - {1'b0, den}) : trial[DIM_W-1:0];
            low_reg[i] <= {l_in[DIM_W-2:0], 1'b0};
            q_reg[i]   <= {q_in[DIM_W-2:0], ge};
        end
    end

    assign quo = q_reg[DIM_W-1];

endmodule

// ----- src/afnm_back.sv -----
// Back part: divides out the source column and row and registers the result.
module afnm_back
    import afnm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    input  cfg_t    cfg,
    output logic    pop,
    output logic    done,
    output result_t result
);

    logic                valid_reg  [DIM_W];
    logic                inside_reg [DIM_W];
    logic                ok_reg     [DIM_W];
    logic [OFFSET_W-1:0] off_reg    [DIM_W];
    logic [DIM_W-1:0]    col_q, row_q;
    logic                done_reg;
    result_t             result_reg;

    afnm_div_pipe u_col_div (
        .clk (clk),
        .num (job.col_num),
        .den (cfg.fit_width),
        .quo (col_q)
    );

    afnm_div_pipe u_row_div (
        .clk (clk),
        .num (job.row_num),
        .den (cfg.fit_height),
        .quo (row_q)
    );

    assign pop = job_valid;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIM_W; i++)
        begin
            inside_reg[i] <= (i == 0) ? job.in_image  : inside_reg[i-1];
            ok_reg[i]     <= (i == 0) ? job.write_ok  : ok_reg[i-1];
            off_reg[i]    <= (i == 0) ? job.fb_offset : off_reg[i-1];
        end
        result_reg.in_image  <= inside_reg[DIM_W-1];
        result_reg.src_col   <= inside_reg[DIM_W-1] ? col_q : '0;
        result_reg.src_row   <= inside_reg[DIM_W-1] ? row_q : '0;
        result_reg.fb_offset <= off_reg[DIM_W-1];
        result_reg.write_ok  <= ok_reg[DIM_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIM_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < DIM_W; i++)
            begin
                valid_reg[i] <= (i == 0) ? job_valid : valid_reg[i-1];
            end
            done_reg <= valid_reg[DIM_W-1];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- src/aspect_fit_nearest_scaler_map_top.sv -----
// Top level of the aspect-fit nearest-neighbour scaler address map.
//
//  channel   signals                              transaction
//  item      start, busy, item                    start high and busy low at a clock edge
//  result    done, result                         done high for one cycle
//  config    cfg_we, cfg_index, cfg_data          cfg_we high at a clock edge
//
// One pixel is accepted per clock while busy is low; its result passes two
// front stages, the queue, the 12-stage column and row dividers and the output register.
// After a register write busy stays high while the shared serial divider
// refits the image, one quotient bit per cycle over up to two divisions.
// Reset loads the default configuration and its fit at once. Results cannot be held off.
module aspect_fit_nearest_scaler_map_top
    import afnm_pkg::*;
#(
    parameter int MAX_DIM = 4096
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FB_W-1:0]      cfg_data
);

    cfg_t                  cfg;
    logic                  fit_busy;
    logic                  accept;
    logic                  push;
    job_t                  push_job;
    logic                  pop;
    logic                  not_empty;
    job_t                  head;
    logic [FIFO_CNT_W-1:0] level;

    afnm_fit #(
        .MAX_DIM (MAX_DIM)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (fit_busy)
    );

    // Room is kept in the queue for the two pixels still in the front stages.
    assign busy   = fit_busy || level >= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign accept = start && !busy;

    afnm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .push   (push),
        .job    (push_job)
    );

    afnm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .level     (level)
    );

    afnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (head),
        .cfg       (cfg),
        .pop       (pop),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the aspect-fit nearest-neighbour scaler address map.
`timescale 1ns / 100ps

module testbench;
    import afnm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                item;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FB_W-1:0]      cfg_data;

    aspect_fit_nearest_scaler_map_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Predictor copy of the configuration and the derived fit.
    logic [11:0] p_src_w, p_src_h, p_scr_w, p_scr_h, p_pan_x, p_pan_y;
    logic [15:0] p_stride;
    logic [31:0] p_fb_bytes;
    logic [11:0] p_fit_w, p_fit_h, p_marg_x, p_marg_y;

    item_t   pixel_queue[$];
    result_t expected_pixels[$];
    int      cycle_count;
    int      mismatches;
    int      checked_pixels;
    int      letterbox_seen;
    int      image_seen;
    int      outside_seen;
    bit      quiet;

    function automatic logic [11:0] clamp_dim(logic [31:0] v);
        return v[11:0];
    endfunction

    task automatic recompute_fit();
        longint fw, fh;
        fw = 0;
        fh = 0;
        if (p_src_w != 0 && p_src_h != 0)
        begin
            fw = p_scr_w;
            fh = (longint'(p_src_h) * p_scr_w) / p_src_w;
            if (fh > p_scr_h)
            begin
                fh = p_scr_h;
                fw = (longint'(p_src_w) * p_scr_h) / p_src_h;
            end
        end
        p_fit_w  = fw[11:0];
        p_fit_h  = fh[11:0];
        p_marg_x = (p_scr_w - p_fit_w) / 2;
        p_marg_y = (p_scr_h - p_fit_h) / 2;
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_SOURCE_WIDTH:  p_src_w = clamp_dim(val);
            REG_SOURCE_HEIGHT: p_src_h = clamp_dim(val);
            REG_SCREEN_WIDTH:  p_scr_w = clamp_dim(val);
            REG_SCREEN_HEIGHT: p_scr_h = clamp_dim(val);
            REG_LINE_STRIDE:   p_stride = val[15:0];
            REG_PAN_X:         p_pan_x = val[11:0];
            REG_PAN_Y:         p_pan_y = val[11:0];
            REG_FB_BYTES:      p_fb_bytes = val;
            default:           return;
        endcase
        recompute_fit();
    endtask

    function automatic result_t map_pixel(item_t px);
        result_t r;
        longint dx, dy, line_base, u, t, row_start;
        dx = px.dest_x;
        dy = px.dest_y;
        line_base = (dy + p_pan_y) * longint'(p_stride);
        r = '0;
        r.fb_offset = 30'(line_base + (dx + p_pan_x) * 4);
        if (dx < p_scr_w && dy < p_scr_h)
        begin
            if (dx >= p_marg_x && dx < longint'(p_marg_x) + p_fit_w &&
                dy >= p_marg_y && dy < longint'(p_marg_y) + p_fit_h)
            begin
                u = dx - p_marg_x;
                t = dy - p_marg_y;
                row_start = line_base + (longint'(p_marg_x) + p_pan_x) * 4;
                r.in_image = 1'b1;
                r.src_col = 12'((u * p_src_w) / p_fit_w);
                r.src_row = 12'(((t + 1) * p_src_h - 1) / p_fit_h);
                r.write_ok = (row_start + longint'(p_fit_w) * 4 <= p_fb_bytes);
            end
            else
                r.write_ok = 1'b1;
        end
        return r;
    endfunction

    // Acceptance is judged at the rising edge, where busy still has its pre-edge value.
    bit taken;
    always @(posedge clk)
    begin
        taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            expected_pixels.push_back(map_pixel(item));
            void'(pixel_queue.pop_front());
        end
    end

    // Driver: offers queued pixels, with random idle bursts unless quiet.
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !taken)
                ;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                gap_left <= $urandom_range(1, 11) - 1;
                start <= 1'b0;
            end
            else if (pixel_queue.size() > 0)
            begin
                start <= 1'b1;
                item <= pixel_queue[0];
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                result_t want;
                want = expected_pixels.pop_front();
                checked_pixels <= checked_pixels + 1;
                if (want.in_image)
                    image_seen <= image_seen + 1;
                else if (want.write_ok)
                    letterbox_seen <= letterbox_seen + 1;
                else
                    outside_seen <= outside_seen + 1;
                if (result.in_image !== want.in_image || result.src_col !== want.src_col ||
                    result.src_row !== want.src_row ||
                    result.fb_offset !== want.fb_offset ||
                    result.write_ok !== want.write_ok)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_register(idx, val);
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || expected_pixels.size() != 0 || start)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic push_pixel(int x, int y);
        item_t px;
        px.dest_x = x[11:0];
        px.dest_y = y[11:0];
        pixel_queue.push_back(px);
    endtask

    // Mostly visible pixels, some beyond the screen and some fully random.
    task automatic random_pixels(int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0:       push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                1:       push_pixel($urandom_range(p_scr_w, 4095), $urandom_range(0, 4095));
                default: push_pixel($urandom_range(0, p_scr_w - 1),
                                    $urandom_range(0, p_scr_h - 1));
            endcase
        end
    endtask

    typedef logic [31:0] cfg_set_t[8];

    initial
    begin
        cfg_set_t settings[6];
        int s, r;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        mismatches = 0;
        checked_pixels = 0;
        letterbox_seen = 0;
        image_seen = 0;
        outside_seen = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        p_src_w = 320; p_src_h = 240; p_scr_w = 1024; p_scr_h = 768;
        p_stride = 4096; p_pan_x = 0; p_pan_y = 0; p_fb_bytes = 3145728;
        recompute_fit();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed pixels under the reset configuration.
        push_pixel(0, 0);
        push_pixel(1023, 767);
        push_pixel(1024, 0);
        push_pixel(0, 768);
        push_pixel(4095, 4095);
        push_pixel(512, 384);
        push_pixel(1023, 0);
        push_pixel(0, 767);
        wait_idle();

        // Wide source so letterbox bars appear above and below.
        write_register(REG_SOURCE_WIDTH, 400);
        write_register(REG_SOURCE_HEIGHT, 100);
        write_register(4'd9, 7);
        write_register(REG_FB_BYTES, 1000000);
        push_pixel(10, 0);
        push_pixel(10, 500);
        push_pixel(1023, 383);
        push_pixel(0, 767);
        push_pixel(2048, 1365);
        wait_idle();

        // Zero source width, then a zero-height fit.
        write_register(REG_SOURCE_WIDTH, 0);
        push_pixel(5, 5);
        wait_idle();
        write_register(REG_SOURCE_WIDTH, 4095);
        write_register(REG_SOURCE_HEIGHT, 1);
        write_register(REG_SCREEN_WIDTH, 100);
        push_pixel(50, 384);
        push_pixel(99, 767);
        wait_idle();

        settings[0] = '{1, 1, 1, 1, 4, 0, 0, 0};
        settings[1] = '{4095, 4095, 4095, 4095, 65535, 4095, 4095, 32'hFFFF_FFFF};
        settings[2] = '{320, 240, 1024, 768, 4096, 0, 0, 3145728};
        settings[3] = '{160, 144, 640, 480, 2560, 17, 9, 1228800};
        settings[4] = '{3, 2000, 4000, 37, 16000, 100, 3000, 50000000};
        settings[5] = '{4095, 4095, 64, 64, 256, 0, 0, 32'hFFFF_FFFF};

        for (s = 0; s < 6; s++)
        begin
            for (r = 0; r < 8; r++)
                write_register(r[CFG_IDX_W-1:0], settings[s][r]);
            push_pixel(0, 0);
            push_pixel(p_scr_w - 1, p_scr_h - 1);
            push_pixel(p_scr_w, p_scr_h);
            random_pixels(200);
            wait_idle();
        end

        // Random configurations with random pixels.
        for (s = 0; s < 4; s++)
        begin
            write_register(REG_SOURCE_WIDTH, $urandom_range(0, 4095));
            write_register(REG_SOURCE_HEIGHT, $urandom_range(1, 4095));
            write_register(REG_SCREEN_WIDTH, $urandom_range(1, 4095));
            write_register(REG_SCREEN_HEIGHT, $urandom_range(1, 4095));
            write_register(REG_LINE_STRIDE, $urandom_range(4, 65535));
            write_register(REG_PAN_X, $urandom_range(0, 4095));
            write_register(REG_PAN_Y, $urandom_range(0, 4095));
            write_register(REG_FB_BYTES, $urandom());
            random_pixels(100);
            wait_idle();
        end

        // Final stretch with no idle gaps.
        quiet = 1'b1;
        random_pixels(80);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d pixels over directed, fixed and random configurations:",
                 checked_pixels);
        $display("%0d image, %0d letterbox, %0d off-screen; %0d mismatches.",
                 image_seen, letterbox_seen, outside_seen, mismatches);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
